// File: rtl/scbs_pkg.sv
// ----------------------------------------------------------------------------
// scbs_pkg: shared definitions for the sorted column search block
// Sizes, function codes, register indexes and the request/result structs
// passed between the top level and the search sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package scbs_pkg;

  // Store geometry
  localparam int ROWS     = 1024;
  localparam int TABLES   = 4;
  localparam int KEY_BITS = 32;

  localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TBL_W    = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int ADDR_W   = ROW_AW + TBL_W;
  localparam int DEPTH    = TABLES * (1 << ROW_AW);

  // Port field widths
  localparam int FUNC_W   = 2;
  localparam int SEL_W    = 2;
  localparam int CNT_W    = 11;
  localparam int NUM_REGS = 4;
  localparam int CFG_IW   = 2;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXACT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLOOR = 2'd2;

  // Row count register indexes
  localparam logic [CFG_IW-1:0] REG_ROWS_T0 = 2'd0;
  localparam logic [CFG_IW-1:0] REG_ROWS_T1 = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ROWS_T2 = 2'd2;
  localparam logic [CFG_IW-1:0] REG_ROWS_T3 = 2'd3;

  localparam logic [CNT_W-1:0] ROWS_MAX = CNT_W'(ROWS);

  // Search request from the top level to the sequencer
  typedef struct packed {
    logic                go;
    logic                is_floor;
    logic [SEL_W-1:0]    tbl;
    logic [KEY_BITS-1:0] target;
    logic [CNT_W-1:0]    count;
  } srch_req_t;

  // Finished search result
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] row;
  } srch_res_t;

  // Memory address of a 1-based row in a table
  function automatic logic [ADDR_W-1:0] key_addr(input logic [SEL_W-1:0] tbl,
                                                 input logic [CNT_W-1:0] row);
    logic [CNT_W-1:0] row_m1;
    row_m1 = row - CNT_W'(1);
    return {tbl[TBL_W-1:0], row_m1[ROW_AW-1:0]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/sorted_column_binary_search.sv
// A write goes into the key memory on its input transfer. A search passes through
// a probe and a compare state per midpoint probe (at most 11 probes for 1024 rows),
// leaves from the probe state when the window empties, takes a post and a back or
// forward state per step of a not-greater search, and passes start and hand-off states.
// The input stalls until the result enters the output register; a held output keeps the search in its done state.
// Reset clears control and the row counts to 0; the key memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_column_binary_search: sorted key column search block
// Stores ascending key columns per table and answers exact and not-greater
// searches with an iterative binary search over the key memory.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_column_binary_search (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [scbs_pkg::FUNC_W-1:0]      in_func,
  input  wire logic [scbs_pkg::SEL_W-1:0]       in_table_select,
  input  wire logic [scbs_pkg::CNT_W-1:0]       in_row,
  input  wire logic [scbs_pkg::KEY_BITS-1:0]    in_key,
  input  wire logic [scbs_pkg::KEY_BITS-1:0]    in_target,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [scbs_pkg::CNT_W-1:0]       out_result_row,
  // Configuration channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [scbs_pkg::CFG_IW-1:0]      cfg_index,
  input  wire logic [scbs_pkg::CNT_W-1:0]       cfg_data
);

  import scbs_pkg::*;

  logic                in_xfer;
  logic                seq_idle;
  logic                res_take;
  logic                row_ok;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [KEY_BITS-1:0] ram_rdata;
  logic [CNT_W-1:0]    sel_count;
  srch_req_t           req;
  srch_res_t           res;
  logic                out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]    out_row_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = !seq_idle;
  assign in_xfer   = in_valid && !in_stall;

  // Row count registers
  scbs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .sel      (in_table_select),
    .count    (sel_count)
  );

  // Key write on a write transfer inside the store
  assign row_ok    = (in_row != '0) && (in_row <= ROWS_MAX)
                     && (int'(in_table_select) < TABLES);
  assign ram_we    = in_xfer && (in_func == FUNC_WRITE) && row_ok;
  assign ram_waddr = key_addr(in_table_select, in_row);

  scbs_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_key),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Start a search on a search transfer
  assign req.go       = in_xfer && ((in_func == FUNC_EXACT) || (in_func == FUNC_FLOOR));
  assign req.is_floor = (in_func == FUNC_FLOOR);
  assign req.tbl      = in_table_select;
  assign req.target   = in_target;
  assign req.count    = sel_count;

  scbs_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .res_take (res_take),
    .rd_data  (ram_rdata),
    .rd_addr  (ram_raddr),
    .idle     (seq_idle),
    .res      (res)
  );

  // Output register: load when empty or draining
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      out_row_r <= res.row;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_row = out_row_r;

  // Checks
  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> seq_idle)
    else $error("key write while a search is running");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |=> in_stall)
    else $error("input not stalled after a search start");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_row <= ROWS_MAX))
    else $error("result row beyond the table");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res_take) |=> (out_valid && !seq_idle) || (out_valid && seq_idle))
    else $error("finished result not loaded into the output register");

endmodule

`default_nettype wire

// File: rtl/scbs_ram.sv
// ----------------------------------------------------------------------------
// scbs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/scbs_cfg.sv
// ----------------------------------------------------------------------------
// scbs_cfg: row count registers
// Holds the per-table row counts and returns the saturated count of the
// selected table; a table outside the store reads as empty.
// ----------------------------------------------------------------------------
`default_nettype none

module scbs_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [scbs_pkg::CFG_IW-1:0]   wr_index,
  input  wire logic [scbs_pkg::CNT_W-1:0]    wr_data,
  input  wire logic [scbs_pkg::SEL_W-1:0]    sel,
  output logic      [scbs_pkg::CNT_W-1:0]    count
);

  import scbs_pkg::*;

  logic [CNT_W-1:0] rows_r [NUM_REGS];
  logic [CNT_W-1:0] raw;

  // Store a count on each write transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rows_r[i] <= '0;
      end
    end else if (wr_en && (int'(wr_index) < NUM_REGS)) begin
      rows_r[wr_index] <= wr_data;
    end
  end

  // Select and saturate
  always_comb begin
    raw = '0;
    if ((int'(sel) < TABLES) && (int'(sel) < NUM_REGS)) begin
      raw = rows_r[sel];
    end
    count = (raw > ROWS_MAX) ? ROWS_MAX : raw;
  end

endmodule

`default_nettype wire

// File: rtl/scbs_seq.sv
// ----------------------------------------------------------------------------
// scbs_seq: binary search sequencer
// Drives the key memory read port one probe at a time and uses a single
// key comparator for the midpoint probe, the backward step and the forward
// step of the not-greater search.
// ----------------------------------------------------------------------------
`default_nettype none

module scbs_seq (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire scbs_pkg::srch_req_t              req,
  input  wire logic                             res_take,
  input  wire logic [scbs_pkg::KEY_BITS-1:0]    rd_data,
  output logic      [scbs_pkg::ADDR_W-1:0]      rd_addr,
  output logic                                  idle,
  output scbs_pkg::srch_res_t                   res
);

  import scbs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PROBE = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_POST  = 7'b0001000,
    S_BACK  = 7'b0010000,
    S_FWD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hi_r, hi_nxt;
  logic [CNT_W-1:0]    mid_r, mid_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    row_r, row_nxt;
  logic [KEY_BITS-1:0] tgt_r, tgt_nxt;
  logic [SEL_W-1:0]    tbl_r, tbl_nxt;
  logic                floor_r, floor_nxt;
  logic                gt_r, gt_nxt;

  logic [CNT_W:0]      mid_sum;
  logic [CNT_W-1:0]    mid_c;
  logic                key_eq;
  logic                key_lt;
  logic                key_gt;

  // Shared key comparator
  assign key_eq = (rd_data == tgt_r);
  assign key_lt = (rd_data < tgt_r);
  assign key_gt = !key_eq && !key_lt;

  // Midpoint of the current window
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c   = mid_sum[CNT_W:1];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    tgt_nxt   = tgt_r;
    tbl_nxt   = tbl_r;
    floor_nxt = floor_r;
    gt_nxt    = gt_r;
    rd_addr   = key_addr(tbl_r, mid_c);

    case (state_r)
      S_IDLE: begin
        if (req.go) begin
          lo_nxt    = CNT_W'(1);
          hi_nxt    = req.count;
          cnt_nxt   = req.count;
          tgt_nxt   = req.target;
          tbl_nxt   = req.tbl;
          floor_nxt = req.is_floor;
          gt_nxt    = 1'b0;
          if (req.count == '0) begin
            row_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        // Issue the midpoint read, or leave when the window is empty
        if (lo_r <= hi_r) begin
          mid_nxt   = mid_c;
          state_nxt = S_CMP;
        end else if (floor_r) begin
          state_nxt = S_POST;
        end else begin
          row_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        if (key_eq) begin
          gt_nxt = 1'b0;
          if (floor_r) begin
            state_nxt = S_POST;
          end else begin
            row_nxt   = mid_r;
            state_nxt = S_DONE;
          end
        end else if (key_lt) begin
          gt_nxt    = 1'b0;
          lo_nxt    = mid_r + CNT_W'(1);
          state_nxt = S_PROBE;
        end else begin
          gt_nxt    = 1'b1;
          hi_nxt    = mid_r - CNT_W'(1);
          state_nxt = S_PROBE;
        end
      end
      S_POST: begin
        // Step back past greater keys, or forward over not-greater keys
        if (gt_r) begin
          if (mid_r == CNT_W'(1)) begin
            row_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            mid_nxt   = mid_r - CNT_W'(1);
            rd_addr   = key_addr(tbl_r, mid_r - CNT_W'(1));
            state_nxt = S_BACK;
          end
        end else if (mid_r < cnt_r) begin
          rd_addr   = key_addr(tbl_r, mid_r + CNT_W'(1));
          state_nxt = S_FWD;
        end else begin
          row_nxt   = mid_r;
          state_nxt = S_DONE;
        end
      end
      S_BACK: begin
        if (key_gt) begin
          state_nxt = S_POST;
        end else begin
          row_nxt   = mid_r;
          state_nxt = S_DONE;
        end
      end
      S_FWD: begin
        if (key_gt) begin
          row_nxt   = mid_r;
          state_nxt = S_DONE;
        end else begin
          mid_nxt   = mid_r + CNT_W'(1);
          state_nxt = S_POST;
        end
      end
      S_DONE: begin
        // Hold the result until the output register takes it
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Search datapath
  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    cnt_r   <= cnt_nxt;
    row_r   <= row_nxt;
    tgt_r   <= tgt_nxt;
    tbl_r   <= tbl_nxt;
    floor_r <= floor_nxt;
    gt_r    <= gt_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res.valid = (state_r == S_DONE);
  assign res.row   = row_r;

endmodule

`default_nettype wire
